@@ rtl/core/sfps_pkg.sv @@
package sfps_pkg;

    localparam int MAX_FLAPS = 64;

    localparam int FLAP_W  = 6;
    localparam int COUNT_W = 7;
    localparam int STEP_W  = 16;
    localparam int NUDGE_W = 8;
    localparam int ADJ_W   = 17;
    localparam int BASE_W  = ADJ_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STEPS = 2'd3;

    localparam logic [NUDGE_W-1:0] ADJUST_STEP_RST   = 8'd10;
    localparam logic [STEP_W-1:0]  DEFAULT_STEPS_RST = 16'd2048;

    typedef enum logic [2:0] {
        OP_SHOW      = 3'd0,
        OP_NEXT      = 3'd1,
        OP_PREV      = 3'd2,
        OP_NUDGE_FWD = 3'd3,
        OP_NUDGE_BCK = 3'd4,
        OP_COMMIT    = 3'd5,
        OP_CALIBRATE = 3'd6,
        OP_LOAD      = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_MOVE      = 2'd1,
        CMD_STORE_OFS = 2'd2,
        CMD_CALIBRATE = 2'd3
    } command_t;

    // Result of the steps-per-flap division handed from the divider to the table fill.
    typedef struct packed {
        logic                  done;
        logic [STEP_W-1:0]     quotient;
        logic [COUNT_W-1:0]    remainder;
    } div_result_t;

endpackage

@@ rtl/core/sfps_divider.sv @@
module sfps_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [sfps_pkg::STEP_W-1:0]  dividend,
    input  logic [sfps_pkg::COUNT_W-1:0] divisor,
    output sfps_pkg::div_result_t     result
);
    import sfps_pkg::*;

    localparam int CNT_W = $clog2(STEP_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STEP_W-1:0]   quo_reg, quo_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W:0]    partial;
    logic                fits;

    // Restoring division, one quotient bit per cycle.
    assign partial = {rem_reg, quo_reg[STEP_W-1]};
    assign fits    = partial >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[STEP_W-2:0], fits};
            rem_next = fits ? COUNT_W'(partial - {1'b0, divisor}) : partial[COUNT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEP_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

@@ rtl/core/split_flap_position_stepper_core.sv @@
// An accepted item passes through ST_RD_S, ST_RD_T and ST_CALC; ST_CALC holds while a result is unaccepted.
// A new item is accepted only in ST_IDLE, after the previous one is through its two flap start table reads.
// A write to flap_count or steps_per_rev rebuilds the table through ST_DINIT, ST_DIV
// (the bit-serial divider) and ST_FILL; no item is accepted meanwhile.
// Reset is synchronous: configuration registers go to their defaults and the flap state clears;
// the table is left unfilled, which is harmless while flap_count is zero.
module split_flap_position_stepper_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sfps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfps_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // target_flap[5:0], offset_value[21:6], slave_ready[22], zero
    input  logic [2:0]  s_tuser,   // opcode
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // command_value[15:0], current_flap[21:16], pending_adjust[38:22], stored_offset[54:39], zero
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser    // command
);
    import sfps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DINIT,
        ST_DIV,
        ST_FILL,
        ST_RD_S,
        ST_RD_T,
        ST_CALC
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [COUNT_W-1:0] flap_count_reg;
    logic [STEP_W-1:0]  steps_per_rev_reg;
    logic [NUDGE_W-1:0] adjust_step_reg;
    logic [STEP_W-1:0]  default_steps_reg;

    // Drum state.
    logic [FLAP_W-1:0]  cur_flap_reg, cur_flap_next;
    logic [ADJ_W-1:0]   adjust_reg, adjust_next;
    logic [STEP_W-1:0]  offset_reg, offset_next;

    // Latched item.
    opcode_t            op_reg;
    logic [FLAP_W-1:0]  tgt_reg;
    logic [STEP_W-1:0]  oval_reg;
    logic               ready_reg;

    // Table fill.
    logic [COUNT_W-1:0] fill_idx_reg;
    logic [STEP_W-1:0]  fill_acc_reg;
    logic [COUNT_W-1:0] fill_rem_reg;
    logic [COUNT_W:0]   fill_sum;
    logic               fill_carry;

    // Flap start table: entry i holds floor(i*S/F).
    logic [STEP_W-1:0]  table_mem [MAX_FLAPS];
    logic [STEP_W-1:0]  rd_data_reg;
    logic [FLAP_W-1:0]  rd_addr;
    logic               wr_en;
    logic [STEP_W-1:0]  start_s_reg;

    logic               div_start;
    div_result_t        div_res;

    // Output register.
    logic               m_valid_reg;
    command_t           cmd_reg, cmd_next;
    logic [STEP_W-1:0]  val_reg, val_next;

    logic [COUNT_W-1:0] eff_flaps;
    logic [FLAP_W-1:0]  s_idx, t_idx;
    logic [COUNT_W-1:0] c_plus;
    logic               move_ok;
    logic [STEP_W-1:0]  fwd_steps;
    logic signed [BASE_W-1:0] base, s_ext, a_ext;
    logic [STEP_W-1:0]  committed;
    logic               rebuild;

    sfps_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (steps_per_rev_reg),
        .divisor  (eff_flaps),
        .result   (div_res)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_DINIT);
    assign rebuild   = cfg_valid && (cfg_index == CFG_FLAP_COUNT ||
                                     cfg_index == CFG_STEPS_PER_REV);

    assign eff_flaps = (flap_count_reg > COUNT_W'(MAX_FLAPS)) ? COUNT_W'(MAX_FLAPS)
                                                              : flap_count_reg;

    // Next start is the previous one plus S/F, with the remainder carried over.
    assign fill_sum   = {1'b0, fill_rem_reg} + {1'b0, div_res.remainder};
    assign fill_carry = fill_sum >= {1'b0, eff_flaps};
    assign wr_en      = (state_reg == ST_FILL) && (fill_idx_reg != eff_flaps);

    // A flap index past a lowered flap count reads as flap 0.
    always_comb begin
        s_idx  = ({1'b0, cur_flap_reg} < eff_flaps) ? cur_flap_reg : '0;
        c_plus = {1'b0, s_idx} + 1'b1;
        t_idx  = tgt_reg;
        unique case (op_reg)
            OP_NEXT: t_idx = (c_plus >= eff_flaps) ? '0 : c_plus[FLAP_W-1:0];
            OP_PREV: t_idx = (s_idx == '0) ? FLAP_W'(eff_flaps - 1'b1) : s_idx - 1'b1;
            default: t_idx = tgt_reg;
        endcase
    end

    assign rd_addr = (state_reg == ST_RD_S) ? s_idx : t_idx;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[fill_idx_reg[FLAP_W-1:0]] <= fill_acc_reg;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // Item evaluation; rd_data_reg holds the start of the target flap in ST_CALC.
    always_comb begin
        move_ok = 1'b0;
        unique case (op_reg)
            OP_SHOW:          move_ok = (eff_flaps != '0) && ({1'b0, tgt_reg} < eff_flaps);
            OP_NEXT, OP_PREV: move_ok = (eff_flaps != '0);
            default:          move_ok = 1'b0;
        endcase

        fwd_steps = (t_idx >= s_idx) ? rd_data_reg - start_s_reg
                                     : steps_per_rev_reg - start_s_reg + rd_data_reg;

        base  = $signed({{(BASE_W-STEP_W){1'b0}}, offset_reg})
              + $signed({{(BASE_W-ADJ_W){adjust_reg[ADJ_W-1]}}, adjust_reg});
        s_ext = $signed({{(BASE_W-STEP_W){1'b0}}, steps_per_rev_reg});
        a_ext = $signed({{(BASE_W-NUDGE_W){1'b0}}, adjust_step_reg});

        committed = (base >= 0 && base <= s_ext) ? base[STEP_W-1:0] : offset_reg;
        if (committed > steps_per_rev_reg) begin
            committed = '0;
        end

        cmd_next      = CMD_NONE;
        val_next      = '0;
        cur_flap_next = cur_flap_reg;
        adjust_next   = adjust_reg;
        offset_next   = offset_reg;
        unique case (op_reg)
            OP_SHOW, OP_NEXT, OP_PREV: begin
                if (move_ok && fwd_steps != '0 && ready_reg) begin
                    cmd_next      = CMD_MOVE;
                    val_next      = fwd_steps;
                    cur_flap_next = t_idx;
                end
            end
            OP_NUDGE_FWD: begin
                if (ready_reg && adjust_step_reg != '0 && base + a_ext <= s_ext) begin
                    adjust_next = adjust_reg + {{(ADJ_W-NUDGE_W){1'b0}}, adjust_step_reg};
                    cmd_next    = CMD_MOVE;
                    val_next    = {{(STEP_W-NUDGE_W){1'b0}}, adjust_step_reg};
                end
            end
            OP_NUDGE_BCK: begin
                if (adjust_step_reg != '0 && base - a_ext >= 0) begin
                    adjust_next = adjust_reg - {{(ADJ_W-NUDGE_W){1'b0}}, adjust_step_reg};
                end
            end
            OP_COMMIT: begin
                offset_next = committed;
                adjust_next = '0;
                if (ready_reg) begin
                    cmd_next = CMD_STORE_OFS;
                    val_next = committed;
                end
            end
            OP_CALIBRATE: begin
                if (ready_reg) begin
                    cmd_next      = CMD_CALIBRATE;
                    val_next      = (steps_per_rev_reg != '0) ? steps_per_rev_reg
                                                              : default_steps_reg;
                    cur_flap_next = '0;
                end
            end
            OP_LOAD: begin
                offset_next = oval_reg;
            end
            default: begin
                offset_next = offset_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            flap_count_reg    <= '0;
            steps_per_rev_reg <= '0;
            adjust_step_reg   <= ADJUST_STEP_RST;
            default_steps_reg <= DEFAULT_STEPS_RST;
            cur_flap_reg      <= '0;
            adjust_reg        <= '0;
            offset_reg        <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_FLAP_COUNT:    flap_count_reg    <= cfg_data[COUNT_W-1:0];
                    CFG_STEPS_PER_REV: steps_per_rev_reg <= cfg_data[STEP_W-1:0];
                    CFG_ADJUST_STEP:   adjust_step_reg   <= cfg_data[NUDGE_W-1:0];
                    CFG_DEFAULT_STEPS: default_steps_reg <= cfg_data[STEP_W-1:0];
                    default:           adjust_step_reg   <= adjust_step_reg;
                endcase
            end

            if (rebuild) begin
                state_reg <= ST_DINIT;
            end else begin
                unique case (state_reg)
                    ST_IDLE: begin
                        if (s_tvalid) begin
                            op_reg    <= opcode_t'(s_tuser);
                            tgt_reg   <= s_tdata[5:0];
                            oval_reg  <= s_tdata[21:6];
                            ready_reg <= s_tdata[22];
                            state_reg <= ST_RD_S;
                        end
                    end
                    ST_DINIT: begin
                        state_reg <= ST_DIV;
                    end
                    ST_DIV: begin
                        if (div_res.done) begin
                            fill_idx_reg <= '0;
                            fill_acc_reg <= '0;
                            fill_rem_reg <= '0;
                            state_reg    <= ST_FILL;
                        end
                    end
                    ST_FILL: begin
                        if (fill_idx_reg == eff_flaps) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            fill_idx_reg <= fill_idx_reg + 1'b1;
                            fill_acc_reg <= fill_acc_reg + div_res.quotient
                                          + {{(STEP_W-1){1'b0}}, fill_carry};
                            fill_rem_reg <= fill_carry ? COUNT_W'(fill_sum - {1'b0, eff_flaps})
                                                       : fill_sum[COUNT_W-1:0];
                        end
                    end
                    ST_RD_S: begin
                        state_reg <= ST_RD_T;
                    end
                    ST_RD_T: begin
                        start_s_reg <= rd_data_reg;
                        state_reg   <= ST_CALC;
                    end
                    ST_CALC: begin
                        if (!m_valid_reg || m_tready) begin
                            cmd_reg      <= cmd_next;
                            val_reg      <= val_next;
                            cur_flap_reg <= cur_flap_next;
                            adjust_reg   <= adjust_next;
                            offset_reg   <= offset_next;
                            m_valid_reg  <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = cmd_reg;
    assign m_tdata  = {1'b0, offset_reg, adjust_reg, cur_flap_reg, val_reg};

endmodule
